// ===== src/satt_pkg.sv =====
// Shared types and constants of the set-associative transposition table.
package satt_pkg;

  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 8;
  localparam int NODES_W = 56;
  localparam int CNT_W   = 48;
  localparam int IDX_W   = 5;

  localparam logic [IDX_W-1:0] INDEX_BITS_RESET = 5'd16;

  // func codes of an input word
  localparam logic [1:0] FUNC_PROBE = 2'd0;
  localparam logic [1:0] FUNC_STORE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_PROBE,
    OP_STORE,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_IDLE,
    BK_EVAL,
    BK_CLEAR
  } bk_state_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [KEY_W-1:0]   key;
    logic [DEPTH_W-1:0] depth;
    logic [NODES_W-1:0] nodes;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic [NODES_W-1:0] found_nodes;
    logic               stored;
    logic               duplicate;
    logic [1:0]         way_used;
    logic [CNT_W-1:0]   hit_total;
    logic [CNT_W-1:0]   miss_total;
    logic [CNT_W-1:0]   fill_total;
    logic [CNT_W-1:0]   collision_total;
  } out_t;

  typedef struct packed {
    op_t                op;
    logic [KEY_W-1:0]   key;
    logic [DEPTH_W-1:0] depth;
    logic [NODES_W-1:0] nodes;
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DEPTH_W-1:0] depth;
    logic [NODES_W-1:0] count;
  } entry_t;

endpackage

// ===== src/set_assoc_transposition_table_core.sv =====
// Top level of the set-associative transposition table with depth replacement.
//
//  channel  | handshake        | payload          | word moved
//  ---------+------------------+------------------+---------------------------------
//  input    | push / full      | item  (in_t)     | probe, store or clear request
//  result   | pop / empty      | result (out_t)   | outcome plus counters after it
//  config   | cfg_we           | cfg_data (5 b)   | index_bits, no read-back
//
//  Probe, store and unused func: set row read in IDLE, then compare in EVAL and,
//  for a store that misses, row write-back on the single-ported set memory.
//  Clear: one set row zeroed per cycle over all 2^SET_BITS rows, result pushed with the last.
//  Reset: the same sweep over all 2^SET_BITS rows runs; full stays high meanwhile.
//  Stalls: a QUEUE_DEPTH command queue and a QUEUE_DEPTH result queue decouple
//  input, back end and result side; the back end waits only on a full result queue.
module set_assoc_transposition_table_core #(
  parameter int SET_BITS    = 16,
  parameter int WAYS        = 4,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  // input words
  input  logic                        push,
  output logic                        full,
  input  satt_pkg::in_t               item,
  // result words
  output logic                        empty,
  input  logic                        pop,
  output satt_pkg::out_t              result,
  // configuration
  input  logic                        cfg_we,
  input  logic [satt_pkg::IDX_W-1:0]  cfg_data
);

  localparam int CMD_W = SET_BITS + $bits(satt_pkg::cmd_t);
  localparam int RES_W = $bits(satt_pkg::out_t);

  logic [satt_pkg::IDX_W-1:0] index_bits;

  // front side
  logic                f_push;
  satt_pkg::cmd_t      f_cmd;
  logic [SET_BITS-1:0] f_set;

  // command queue
  logic [CMD_W-1:0]    cq_rdata;
  logic                cq_full;
  logic                cq_empty;
  logic                cq_pop;
  satt_pkg::cmd_t      b_cmd;
  logic [SET_BITS-1:0] b_set;

  // back end / result queue
  logic                init_busy;
  logic                rq_push;
  logic                rq_full;
  satt_pkg::out_t      b_res;
  logic [RES_W-1:0]    rq_rdata;

  // index_bits register; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits <= satt_pkg::INDEX_BITS_RESET;
    end else if (cfg_we) begin
      index_bits <= cfg_data;
    end
  end

  satt_front #(
    .SET_BITS (SET_BITS)
  ) u_front (
    .push       (push),
    .full       (full),
    .item       (item),
    .index_bits (index_bits),
    .init_busy  (init_busy),
    .cmd_full   (cq_full),
    .cmd_push   (f_push),
    .cmd        (f_cmd),
    .set        (f_set)
  );

  // set index rides in the upper bits of each queued command
  satt_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata ({f_set, f_cmd}),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .full  (cq_full),
    .empty (cq_empty)
  );

  assign b_set = cq_rdata[CMD_W-1 -: SET_BITS];
  assign b_cmd = satt_pkg::cmd_t'(cq_rdata[$bits(satt_pkg::cmd_t)-1:0]);

  satt_back #(
    .SET_BITS (SET_BITS),
    .WAYS     (WAYS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cq_empty),
    .cmd       (b_cmd),
    .cmd_set   (b_set),
    .cmd_pop   (cq_pop),
    .out_full  (rq_full),
    .out_push  (rq_push),
    .res       (b_res),
    .init_busy (init_busy)
  );

  // result queue: head word is presented while empty is low
  satt_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .wdata (b_res),
    .pop   (pop),
    .rdata (rq_rdata),
    .full  (rq_full),
    .empty (empty)
  );

  assign result = satt_pkg::out_t'(rq_rdata);

endmodule

// ===== src/satt_fifo.sv =====
// Small register queue used between front and back and on the result side.
module satt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/satt_front.sv =====
// Front end: accepts input words, decodes the operation and forms the set index.
module satt_front #(
  parameter int SET_BITS = 16
) (
  input  logic                        push,
  output logic                        full,
  input  satt_pkg::in_t               item,
  input  logic [satt_pkg::IDX_W-1:0]  index_bits,
  input  logic                        init_busy,
  input  logic                        cmd_full,
  output logic                        cmd_push,
  output satt_pkg::cmd_t              cmd,
  output logic [SET_BITS-1:0]         set
);

  logic [satt_pkg::IDX_W-1:0] eff_bits;

  // no words taken while the table is being swept after reset
  assign full     = cmd_full || init_busy;
  assign cmd_push = push && !full;

  // index_bits beyond the table size acts as the full set width
  assign eff_bits = (index_bits > satt_pkg::IDX_W'(SET_BITS)) ?
                    satt_pkg::IDX_W'(SET_BITS) : index_bits;

  always_comb begin
    for (int i = 0; i < SET_BITS; i++) begin
      set[i] = item.key[i] && (satt_pkg::IDX_W'(i) < eff_bits);
    end
  end

  always_comb begin
    cmd.key   = item.key;
    cmd.depth = item.depth;
    cmd.nodes = item.nodes;
    case (item.func)
      satt_pkg::FUNC_PROBE: cmd.op = satt_pkg::OP_PROBE;
      satt_pkg::FUNC_STORE: cmd.op = satt_pkg::OP_STORE;
      satt_pkg::FUNC_CLEAR: cmd.op = satt_pkg::OP_CLEAR;
      default:              cmd.op = satt_pkg::OP_NOP;
    endcase
  end

endmodule

// ===== src/satt_back.sv =====
// Back end: set memory, hit and replacement logic, counters and clear sweep.
module satt_back #(
  parameter int SET_BITS = 16,
  parameter int WAYS     = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_empty,
  input  satt_pkg::cmd_t        cmd,
  input  logic [SET_BITS-1:0]   cmd_set,
  output logic                  cmd_pop,
  input  logic                  out_full,
  output logic                  out_push,
  output satt_pkg::out_t        res,
  output logic                  init_busy
);

  localparam int NSETS   = 1 << SET_BITS;
  localparam int ENTRY_W = $bits(satt_pkg::entry_t);
  localparam int ROW_W   = ENTRY_W * WAYS;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W   = satt_pkg::CNT_W;

  satt_pkg::bk_state_t state, state_next;

  logic [ROW_W-1:0]    mem [NSETS];
  logic [ROW_W-1:0]    rdata;
  logic                mem_we;
  logic [SET_BITS-1:0] mem_waddr;
  logic [ROW_W-1:0]    mem_wdata;

  satt_pkg::cmd_t      cur_cmd;
  logic [SET_BITS-1:0] cur_set;

  logic [SET_BITS-1:0] sweep_row, sweep_row_next;
  logic                sweep_last;

  logic [CNT_W-1:0] hit_cnt, hit_cnt_next;
  logic [CNT_W-1:0] miss_cnt, miss_cnt_next;
  logic [CNT_W-1:0] fill_cnt, fill_cnt_next;
  logic [CNT_W-1:0] coll_cnt, coll_cnt_next;

  logic               any_match;
  logic [WAY_W-1:0]   match_way;
  logic [WAY_W-1:0]   repl_way;
  logic [satt_pkg::DEPTH_W:0] min_depth;
  satt_pkg::entry_t   old_entry;
  satt_pkg::entry_t   new_entry;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (&c) ? c : c + CNT_W'(1);
  endfunction

  assign sweep_last = &sweep_row;
  assign init_busy  = (state == satt_pkg::BK_INIT);

  // set memory: one row holds all ways of a set; one access per cycle
  always_ff @(posedge clk) begin
    if (!mem_we) begin
      rdata <= mem[cmd_set];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // match search and least-depth replacement over the ways
  always_comb begin
    satt_pkg::entry_t e;
    any_match = 1'b0;
    match_way = '0;
    repl_way  = '0;
    min_depth = 9'h100;
    for (int w = 0; w < WAYS; w++) begin
      e = satt_pkg::entry_t'(rdata[w*ENTRY_W +: ENTRY_W]);
      if (!any_match && e.key == cur_cmd.key && e.depth == cur_cmd.depth) begin
        any_match = 1'b1;
        match_way = WAY_W'(w);
      end
      if (!any_match && {1'b0, e.depth} < min_depth) begin
        min_depth = {1'b0, e.depth};
        repl_way  = WAY_W'(w);
      end
    end
  end

  assign old_entry       = satt_pkg::entry_t'(rdata[repl_way*ENTRY_W +: ENTRY_W]);
  assign new_entry.key   = cur_cmd.key;
  assign new_entry.depth = cur_cmd.depth;
  assign new_entry.count = cur_cmd.nodes;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= satt_pkg::BK_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_row <= '0;
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      fill_cnt  <= '0;
      coll_cnt  <= '0;
    end else begin
      sweep_row <= sweep_row_next;
      hit_cnt   <= hit_cnt_next;
      miss_cnt  <= miss_cnt_next;
      fill_cnt  <= fill_cnt_next;
      coll_cnt  <= coll_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_cmd <= cmd;
      cur_set <= cmd_set;
    end
  end

  always_comb begin
    state_next     = state;
    cmd_pop        = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = sweep_row;
    mem_wdata      = '0;
    out_push       = 1'b0;
    sweep_row_next = sweep_row;
    hit_cnt_next   = hit_cnt;
    miss_cnt_next  = miss_cnt;
    fill_cnt_next  = fill_cnt;
    coll_cnt_next  = coll_cnt;
    res            = '0;

    case (state)
      satt_pkg::BK_INIT: begin
        mem_we         = 1'b1;
        sweep_row_next = sweep_row + SET_BITS'(1);
        if (sweep_last) begin
          state_next = satt_pkg::BK_IDLE;
        end
      end
      satt_pkg::BK_IDLE: begin
        if (!cmd_empty && !out_full) begin
          cmd_pop = 1'b1;
          if (cmd.op == satt_pkg::OP_CLEAR) begin
            state_next     = satt_pkg::BK_CLEAR;
            sweep_row_next = '0;
            hit_cnt_next   = '0;
            miss_cnt_next  = '0;
            fill_cnt_next  = '0;
            coll_cnt_next  = '0;
          end else begin
            state_next = satt_pkg::BK_EVAL;
          end
        end
      end
      satt_pkg::BK_EVAL: begin
        out_push   = 1'b1;
        state_next = satt_pkg::BK_IDLE;
        case (cur_cmd.op)
          satt_pkg::OP_PROBE: begin
            res.hit = any_match;
            if (any_match) begin
              res.found_nodes = rdata[match_way*ENTRY_W +: satt_pkg::NODES_W];
              res.way_used    = 2'(match_way);
              hit_cnt_next    = sat_inc(hit_cnt);
            end else begin
              miss_cnt_next = sat_inc(miss_cnt);
            end
          end
          satt_pkg::OP_STORE: begin
            if (any_match) begin
              res.duplicate = 1'b1;
              res.way_used  = 2'(match_way);
            end else begin
              res.stored = 1'b1;
              res.way_used = 2'(repl_way);
              mem_we    = 1'b1;
              mem_waddr = cur_set;
              mem_wdata = rdata;
              mem_wdata[repl_way*ENTRY_W +: ENTRY_W] = new_entry;
              if (old_entry.key == '0) begin
                fill_cnt_next = sat_inc(fill_cnt);
              end else if (old_entry.key != cur_cmd.key) begin
                coll_cnt_next = sat_inc(coll_cnt);
              end
            end
          end
          default: begin
          end
        endcase
      end
      satt_pkg::BK_CLEAR: begin
        mem_we         = 1'b1;
        sweep_row_next = sweep_row + SET_BITS'(1);
        if (sweep_last) begin
          out_push   = 1'b1;
          state_next = satt_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = satt_pkg::BK_INIT;
      end
    endcase

    res.hit_total       = hit_cnt_next;
    res.miss_total      = miss_cnt_next;
    res.fill_total      = fill_cnt_next;
    res.collision_total = coll_cnt_next;
  end

  // a word in evaluation always has a free result slot
  a_eval_room: assert property (@(posedge clk) disable iff (rst)
    (state == satt_pkg::BK_EVAL) |-> !out_full)
    else $error("result queue full during evaluation");

  // nothing may enter the command queue while the post-reset sweep runs
  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == satt_pkg::BK_INIT) |-> cmd_empty)
    else $error("command accepted during initial sweep");

  a_res_excl: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !(res.stored && res.duplicate) &&
                 !(res.hit && (res.stored || res.duplicate)))
    else $error("conflicting result flags");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (state == satt_pkg::BK_CLEAR) |-> (hit_cnt == '0) && (miss_cnt == '0) &&
                                      (fill_cnt == '0) && (coll_cnt == '0))
    else $error("counters not zero during clear");

  a_cnt_mono: assert property (@(posedge clk) disable iff (rst)
    (state == satt_pkg::BK_EVAL) |=> (hit_cnt >= $past(hit_cnt)) &&
                                     (fill_cnt >= $past(fill_cnt)))
    else $error("counter went backward");

endmodule
